// ===== hdl/cpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpm_pkg
// Shared widths, types and codes for the primaries to colour matrix block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpm_pkg;

    localparam int COORD_W   = 16;
    localparam int COEF_W    = 24;
    localparam int COEF_FRAC = 16;

    // Primaries matrix entries: x, y and z = 1 - x - y as signed values with two bits above the coordinates.
    localparam int P_W   = COORD_W + 2;
    localparam int ADJ_W = 2 * P_W;
    localparam int SUM_W = ADJ_W + P_W + 2;
    localparam int SPLIT = SUM_W / 2;
    localparam int NUM_W = SUM_W + P_W - 2;

    // Divider: one quotient bit per stage, with one bit above the coefficient width to catch overflow.
    localparam int Q_W     = COEF_W + 1;
    localparam int DEN_W   = NUM_W + 1;
    localparam int DIV_W   = NUM_W + Q_W + 1;
    localparam int DIV_LAT = Q_W + 2;

    localparam int FRONT_LAT = 5;

    localparam logic [P_W-1:0] P_UNIT = {2'b01, {COORD_W{1'b0}}};
    localparam logic [Q_W-1:0] COEF_MAX     = {2'b00, {(COEF_W-1){1'b1}}};
    localparam logic [Q_W-1:0] COEF_MIN_MAG = {2'b01, {(COEF_W-1){1'b0}}};

    localparam int NXT1 [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SING = 2'd2;

    localparam int   ADDR_W        = 3;
    localparam int   DATA_W        = 32;
    localparam logic REG_DIRECTION = 1'b0;

    typedef logic signed [P_W-1:0]   t_pval;
    typedef logic signed [ADJ_W-1:0] t_adj;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [NUM_W-1:0] t_num;
    typedef logic [NUM_W-1:0]        t_mag;
    typedef logic [DEN_W-1:0]        t_den;
    typedef logic [DIV_W-1:0]        t_rem;
    typedef logic [Q_W-1:0]          t_quo;
    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic [COORD_W-1:0] red_x;
        logic [COORD_W-1:0] red_y;
        logic [COORD_W-1:0] green_x;
        logic [COORD_W-1:0] green_y;
        logic [COORD_W-1:0] blue_x;
        logic [COORD_W-1:0] blue_y;
        logic [COORD_W-1:0] white_x;
        logic [COORD_W-1:0] white_y;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        t_coef      coef_00;
        t_coef      coef_01;
        t_coef      coef_02;
        t_coef      coef_10;
        t_coef      coef_11;
        t_coef      coef_12;
        t_coef      coef_20;
        t_coef      coef_21;
        t_coef      coef_22;
    } t_result;

    typedef struct packed {
        logic vld;
        logic zero;
        logic dir;
    } t_ctrl;

    typedef struct packed {
        logic       vld;
        logic [1:0] status;
    } t_tail;

endpackage

// ===== hdl/cpm_front.sv =====
// ----------------------------------------------------------------------------
// cpm_front
// Builds the primaries matrix, its cofactors, the determinant and the
// unnormalised white scales, and the cofactors scaled by white y, over five register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  cpm_pkg::t_item     i_item,
    input  logic               i_dir,
    output cpm_pkg::t_ctrl     o_ctl,
    output cpm_pkg::t_pval     o_p [3][3],
    output logic [cpm_pkg::COORD_W-1:0] o_c7,
    output cpm_pkg::t_sum      o_det,
    output cpm_pkg::t_sum      o_a [3],
    output cpm_pkg::t_sum      o_n1 [3][3]
);

    logic [cpm_pkg::COORD_W-1:0] w_c [8];
    logic                        w_zero;
    cpm_pkg::t_pval              w_p [3][3];
    cpm_pkg::t_pval              w_wv [3];

    cpm_pkg::t_ctrl              r_ctl [cpm_pkg::FRONT_LAT];
    cpm_pkg::t_pval              r_p [cpm_pkg::FRONT_LAT][3][3];
    cpm_pkg::t_pval              r_wv [3][3];
    logic [cpm_pkg::COORD_W-1:0] r_c7 [cpm_pkg::FRONT_LAT];
    cpm_pkg::t_adj               r_pa [3][3];
    cpm_pkg::t_adj               r_pb [3][3];
    cpm_pkg::t_adj               r_adj [3][3];
    cpm_pkg::t_sum               r_dt [3];
    cpm_pkg::t_sum               r_at [3][3];
    cpm_pkg::t_sum               r_ca [3][3];
    cpm_pkg::t_sum               r_det;
    cpm_pkg::t_sum               r_a [3];
    cpm_pkg::t_sum               r_n1 [3][3];

    always_comb begin
        w_c[0] = i_item.red_x;
        w_c[1] = i_item.red_y;
        w_c[2] = i_item.green_x;
        w_c[3] = i_item.green_y;
        w_c[4] = i_item.blue_x;
        w_c[5] = i_item.blue_y;
        w_c[6] = i_item.white_x;
        w_c[7] = i_item.white_y;
        w_zero = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (w_c[k] == '0) begin
                w_zero = 1'b1;
            end
        end
        for (int j = 0; j < 3; j++) begin
            w_p[0][j] = cpm_pkg::t_pval'(w_c[2*j]);
            w_p[1][j] = cpm_pkg::t_pval'(w_c[2*j+1]);
            w_p[2][j] = cpm_pkg::P_UNIT - cpm_pkg::t_pval'(w_c[2*j])
                        - cpm_pkg::t_pval'(w_c[2*j+1]);
        end
        w_wv[0] = cpm_pkg::t_pval'(w_c[6]);
        w_wv[1] = cpm_pkg::t_pval'(w_c[7]);
        w_wv[2] = cpm_pkg::P_UNIT - cpm_pkg::t_pval'(w_c[6]) - cpm_pkg::t_pval'(w_c[7]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < cpm_pkg::FRONT_LAT; s++) begin
                r_ctl[s] <= '0;
            end
        end else if (i_en) begin
            r_ctl[0] <= '{vld: i_vld, zero: w_zero, dir: i_dir};
            for (int s = 1; s < cpm_pkg::FRONT_LAT; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]  <= w_p;
            r_wv[0] <= w_wv;
            r_c7[0] <= w_c[7];
            for (int s = 1; s < cpm_pkg::FRONT_LAT; s++) begin
                r_p[s]  <= r_p[s-1];
                r_c7[s] <= r_c7[s-1];
            end
            r_wv[1] <= r_wv[0];
            r_wv[2] <= r_wv[1];
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    // Cofactor products, taken cyclically so no sign flip is needed.
                    r_pa[i][j] <= r_p[0][cpm_pkg::NXT1[j]][cpm_pkg::NXT1[i]]
                                  * r_p[0][cpm_pkg::NXT2[j]][cpm_pkg::NXT2[i]];
                    r_pb[i][j] <= r_p[0][cpm_pkg::NXT1[j]][cpm_pkg::NXT2[i]]
                                  * r_p[0][cpm_pkg::NXT2[j]][cpm_pkg::NXT1[i]];
                    r_adj[i][j] <= r_pa[i][j] - r_pb[i][j];
                    r_at[i][j]  <= r_adj[i][j] * r_wv[2][j];
                    r_ca[i][j]  <= cpm_pkg::t_sum'(r_c7[2]) * r_adj[i][j];
                    r_n1[i][j]  <= r_ca[i][j];
                end
                r_dt[i] <= r_p[2][0][i] * r_adj[i][0];
                r_a[i]  <= r_at[i][0] + r_at[i][1] + r_at[i][2];
            end
            r_det <= r_dt[0] + r_dt[1] + r_dt[2];
        end
    end

    assign o_ctl = r_ctl[cpm_pkg::FRONT_LAT-1];
    assign o_p   = r_p[cpm_pkg::FRONT_LAT-1];
    assign o_c7  = r_c7[cpm_pkg::FRONT_LAT-1];
    assign o_det = r_det;
    assign o_a   = r_a;
    assign o_n1  = r_n1;

endmodule

// ===== hdl/cpm_scale.sv =====
// ----------------------------------------------------------------------------
// cpm_scale
// Forms the numerator and denominator of every coefficient for the selected
// direction, sets the status and splits off signs and magnitudes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpm_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  cpm_pkg::t_ctrl     i_ctl,
    input  cpm_pkg::t_pval     i_p [3][3],
    input  logic [cpm_pkg::COORD_W-1:0] i_c7,
    input  cpm_pkg::t_sum      i_det,
    input  cpm_pkg::t_sum      i_a [3],
    input  cpm_pkg::t_sum      i_n1 [3][3],
    output cpm_pkg::t_tail     o_tail,
    output cpm_pkg::t_mag      o_nm [3][3],
    output cpm_pkg::t_mag      o_dm [3],
    output logic               o_neg [3][3]
);

    cpm_pkg::t_ctrl r_ctl6;
    cpm_pkg::t_tail r_tail7;
    cpm_pkg::t_tail r_tail8;

    cpm_pkg::t_num  r_pl [3][3];
    cpm_pkg::t_num  r_ph [3][3];
    cpm_pkg::t_num  r_dl;
    cpm_pkg::t_num  r_dh;
    logic           r_detz;
    logic           r_az;
    cpm_pkg::t_sum  r_a6 [3];
    cpm_pkg::t_sum  r_n1_6 [3][3];

    cpm_pkg::t_num  r_n [3][3];
    cpm_pkg::t_num  r_d [3];
    cpm_pkg::t_mag  r_nm [3][3];
    cpm_pkg::t_mag  r_dm [3];
    logic           r_ng [3][3];

    cpm_pkg::t_num  w_d0;
    logic [1:0]     w_status;

    // Wide products are taken as two partial products and summed a stage later.
    always_comb begin
        w_d0 = (r_dh <<< cpm_pkg::SPLIT) + r_dl;
        if (r_ctl6.zero) begin
            w_status = cpm_pkg::ST_ZERO;
        end else if (r_detz || (r_ctl6.dir && r_az)) begin
            w_status = cpm_pkg::ST_SING;
        end else begin
            w_status = cpm_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl6  <= '0;
            r_tail7 <= '0;
            r_tail8 <= '0;
        end else if (i_en) begin
            r_ctl6  <= i_ctl;
            r_tail7 <= '{vld: r_ctl6.vld, status: w_status};
            r_tail8 <= r_tail7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl   <= cpm_pkg::t_num'(i_c7)
                      * cpm_pkg::t_num'({1'b0, i_det[cpm_pkg::SPLIT-1:0]});
            r_dh   <= cpm_pkg::t_num'(i_c7)
                      * cpm_pkg::t_num'(signed'(i_det[cpm_pkg::SUM_W-1:cpm_pkg::SPLIT]));
            r_detz <= (i_det == '0);
            r_az   <= (i_a[0] == '0) || (i_a[1] == '0) || (i_a[2] == '0);
            r_a6   <= i_a;
            r_n1_6 <= i_n1;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pl[i][j] <= cpm_pkg::t_num'(i_p[i][j])
                        * cpm_pkg::t_num'({1'b0, i_a[j][cpm_pkg::SPLIT-1:0]});
                    r_ph[i][j] <= cpm_pkg::t_num'(i_p[i][j])
                        * cpm_pkg::t_num'(signed'(i_a[j][cpm_pkg::SUM_W-1:cpm_pkg::SPLIT]));
                    if (r_ctl6.dir) begin
                        r_n[i][j] <= cpm_pkg::t_num'(r_n1_6[i][j]);
                    end else begin
                        r_n[i][j] <= (r_ph[i][j] <<< cpm_pkg::SPLIT) + r_pl[i][j];
                    end
                    r_nm[i][j] <= r_n[i][j][cpm_pkg::NUM_W-1] ?
                                  cpm_pkg::t_mag'(-r_n[i][j]) : cpm_pkg::t_mag'(r_n[i][j]);
                    r_ng[i][j] <= r_n[i][j][cpm_pkg::NUM_W-1] ^ r_d[i][cpm_pkg::NUM_W-1];
                end
                // The inverse divides each row by its own white scale.
                r_d[i]  <= r_ctl6.dir ? cpm_pkg::t_num'(r_a6[i]) : w_d0;
                r_dm[i] <= r_d[i][cpm_pkg::NUM_W-1] ?
                           cpm_pkg::t_mag'(-r_d[i]) : cpm_pkg::t_mag'(r_d[i]);
            end
        end
    end

    assign o_tail = r_tail8;
    assign o_nm   = r_nm;
    assign o_dm   = r_dm;
    assign o_neg  = r_ng;

endmodule

// ===== hdl/cpm_div.sv =====
// ----------------------------------------------------------------------------
// cpm_div
// Pipelined restoring divider for one coefficient: rounds the quotient half
// away from zero, saturates it and applies the sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpm_div (
    input  logic           i_clk,
    input  logic           i_en,
    input  cpm_pkg::t_mag  i_num_mag,
    input  cpm_pkg::t_mag  i_den_mag,
    input  logic           i_neg,
    output cpm_pkg::t_coef o_coef
);

    cpm_pkg::t_rem  r_rem [cpm_pkg::Q_W+1];
    cpm_pkg::t_den  r_den [cpm_pkg::Q_W+1];
    cpm_pkg::t_quo  r_q   [cpm_pkg::Q_W+1];
    logic           r_neg [cpm_pkg::Q_W+1];
    cpm_pkg::t_coef r_coef;

    cpm_pkg::t_quo  w_mag;
    cpm_pkg::t_quo  w_val;

    // Dividing (2n + d) by 2d rounds n / d to nearest, halves away from zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (cpm_pkg::t_rem'(i_num_mag) << (cpm_pkg::COEF_FRAC + 1))
                        + cpm_pkg::t_rem'(i_den_mag);
            r_den[0] <= {i_den_mag, 1'b0};
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
        end
    end

    for (genvar k = 0; k < cpm_pkg::Q_W; k++) begin : g_step
        localparam int SH = cpm_pkg::Q_W - 1 - k;
        cpm_pkg::t_rem           w_sub;
        logic [cpm_pkg::DIV_W:0] w_diff;

        assign w_sub  = cpm_pkg::t_rem'(r_den[k]) << SH;
        assign w_diff = {1'b0, r_rem[k]} - {1'b0, w_sub};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_diff[cpm_pkg::DIV_W]) begin
                    r_rem[k+1] <= w_diff[cpm_pkg::DIV_W-1:0];
                    r_q[k+1]   <= r_q[k] | (cpm_pkg::t_quo'(1) << SH);
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_q[k+1]   <= r_q[k];
                end
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    // The quotient is saturated to the coefficient range before the sign is applied.
    always_comb begin
        if (r_neg[cpm_pkg::Q_W]) begin
            w_mag = (r_q[cpm_pkg::Q_W] > cpm_pkg::COEF_MIN_MAG) ?
                    cpm_pkg::COEF_MIN_MAG : r_q[cpm_pkg::Q_W];
            w_val = -w_mag;
        end else begin
            w_mag = (r_q[cpm_pkg::Q_W] > cpm_pkg::COEF_MAX) ?
                    cpm_pkg::COEF_MAX : r_q[cpm_pkg::Q_W];
            w_val = w_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_coef <= w_val[cpm_pkg::COEF_W-1:0];
        end
    end

    assign o_coef = r_coef;

endmodule

// ===== hdl/cpm_outbuf.sv =====
// ----------------------------------------------------------------------------
// cpm_outbuf
// Output register with a skid stage, so that the pipeline keeps taking
// items while a result waits for its transfer, until the skid stage fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpm_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  cpm_pkg::t_result i_data,
    input  logic             i_ready,
    output logic             o_vld,
    output cpm_pkg::t_result o_data,
    output logic             o_full
);

    logic             r_out_vld;
    logic             r_skid_vld;
    cpm_pkg::t_result r_out;
    cpm_pkg::t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= i_vld;
            end
        end else if (i_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            r_out <= r_skid_vld ? r_skid : i_data;
        end else if (i_vld) begin
            r_skid <= i_data;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_data = r_out;
    assign o_full = r_skid_vld;

endmodule

// ===== hdl/primaries_to_color_matrix.sv =====
// ----------------------------------------------------------------------------
// primaries_to_color_matrix
// A result passes the front, scale and divider stages and the output register;
// the block takes one item per cycle while the skid stage holds no result.
// The depth is set by the nine 27-stage divider lanes, one quotient bit each.
// Reset clears all valid bits and sets the direction register to RGB to XYZ.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module primaries_to_color_matrix (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cpm_pkg::t_item                i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cpm_pkg::t_result              o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpm_pkg::ADDR_W-1:0]    paddr,
    input  logic [cpm_pkg::DATA_W-1:0]    pwdata,
    output logic [cpm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic                        r_direction;
    logic                        w_en;
    logic                        w_full;

    cpm_pkg::t_ctrl              w_fctl;
    cpm_pkg::t_pval              w_p [3][3];
    logic [cpm_pkg::COORD_W-1:0] w_c7;
    cpm_pkg::t_sum               w_det;
    cpm_pkg::t_sum               w_a [3];
    cpm_pkg::t_sum               w_n1 [3][3];

    cpm_pkg::t_tail              w_stail;
    cpm_pkg::t_mag               w_nm [3][3];
    cpm_pkg::t_mag               w_dm [3];
    logic                        w_ng [3][3];
    cpm_pkg::t_coef              w_coef [3][3];
    cpm_pkg::t_coef              w_k [3][3];

    cpm_pkg::t_tail              r_tail [cpm_pkg::DIV_LAT];
    cpm_pkg::t_result            w_res;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[cpm_pkg::ADDR_W-1] == cpm_pkg::REG_DIRECTION) ?
                    {{(cpm_pkg::DATA_W-1){1'b0}}, r_direction} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[cpm_pkg::ADDR_W-1] == cpm_pkg::REG_DIRECTION) begin
            r_direction <= pwdata[0];
        end
    end

    // The whole pipeline advances together unless the skid stage is holding a result.
    assign w_en       = !w_full;
    assign o_in_ready = w_en;

    cpm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_item  (i_in_data),
        .i_dir   (r_direction),
        .o_ctl   (w_fctl),
        .o_p     (w_p),
        .o_c7    (w_c7),
        .o_det   (w_det),
        .o_a     (w_a),
        .o_n1    (w_n1)
    );

    cpm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_fctl),
        .i_p     (w_p),
        .i_c7    (w_c7),
        .i_det   (w_det),
        .i_a     (w_a),
        .i_n1    (w_n1),
        .o_tail  (w_stail),
        .o_nm    (w_nm),
        .o_dm    (w_dm),
        .o_neg   (w_ng)
    );

    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            cpm_div u_div (
                .i_clk     (i_clk),
                .i_en      (w_en),
                .i_num_mag (w_nm[gi][gj]),
                .i_den_mag (w_dm[gi]),
                .i_neg     (w_ng[gi][gj]),
                .o_coef    (w_coef[gi][gj])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < cpm_pkg::DIV_LAT; s++) begin
                r_tail[s] <= '0;
            end
        end else if (w_en) begin
            r_tail[0] <= w_stail;
            for (int s = 1; s < cpm_pkg::DIV_LAT; s++) begin
                r_tail[s] <= r_tail[s-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                w_k[i][j] = (r_tail[cpm_pkg::DIV_LAT-1].status == cpm_pkg::ST_OK) ?
                            w_coef[i][j] : '0;
            end
        end
        w_res.status  = r_tail[cpm_pkg::DIV_LAT-1].status;
        w_res.coef_00 = w_k[0][0];
        w_res.coef_01 = w_k[0][1];
        w_res.coef_02 = w_k[0][2];
        w_res.coef_10 = w_k[1][0];
        w_res.coef_11 = w_k[1][1];
        w_res.coef_12 = w_k[1][2];
        w_res.coef_20 = w_k[2][0];
        w_res.coef_21 = w_k[2][1];
        w_res.coef_22 = w_k[2][2];
    end

    cpm_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_en && r_tail[cpm_pkg::DIV_LAT-1].vld),
        .i_data  (w_res),
        .i_ready (i_out_ready),
        .o_vld   (o_out_valid),
        .o_data  (o_out_data),
        .o_full  (w_full)
    );

endmodule

// ===== hdl/cpm_checker.sv =====
// ----------------------------------------------------------------------------
// cpm_checker
// Port-level checks for the primaries to colour matrix block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input cpm_pkg::t_result           o_out_data
);

    // No result is offered in the cycle after a reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    // A failed status always comes with an all-zero matrix.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != cpm_pkg::ST_OK |->
            o_out_data.coef_00 == '0 && o_out_data.coef_01 == '0 &&
            o_out_data.coef_02 == '0 && o_out_data.coef_10 == '0 &&
            o_out_data.coef_11 == '0 && o_out_data.coef_12 == '0 &&
            o_out_data.coef_20 == '0 && o_out_data.coef_21 == '0 &&
            o_out_data.coef_22 == '0)
        else $error("nonzero coefficient with a failed status");

    // Input back-pressure only ever follows a stalled output.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !o_in_ready |-> $past(o_out_valid && !i_out_ready))
        else $error("input stalled without an output stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

endmodule

bind primaries_to_color_matrix cpm_checker u_checker (.*);
